>>> design/lcpg_pkg.sv
// shared types, constants and the fade arithmetic for the comet pattern generator
// no dependencies; imported by lcpg_cell and led_comet_pattern_generator_unit
package lcpg_pkg;

    // width of the strip length register and of the pixel counters
    localparam int LEN_W = 7;

    // operation codes of the input transaction
    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // control broadcast to every cell of the ring
    typedef struct packed {
        logic             shift;
        logic [LEN_W-1:0] len;
    } cell_ctrl_t;

    // c * scale / 256, truncated
    function automatic logic [7:0] fade_channel(input logic [7:0] c, input logic [8:0] scale);
        logic [16:0] prod;
        prod = {9'b0, c} * {8'b0, scale};
        return prod[15:8];
    endfunction

    function automatic pixel_t fade_pixel(input pixel_t p, input logic [8:0] scale);
        pixel_t q;
        q.red   = fade_channel(p.red, scale);
        q.green = fade_channel(p.green, scale);
        q.blue  = fade_channel(p.blue, scale);
        return q;
    endfunction

endpackage

>>> design/led_comet_pattern_generator_unit.sv
// comet animation generator for one led strip: control, ring of pixel cells, output register
// depends on lcpg_pkg and lcpg_cell
//
// a start or a tick that does not step emits nothing
// a stepping tick emits len pixels, one per cycle unless out_ready stalls, as the ring
//   rotates past cell 0; the first pixel passes the busy flag and then the output register
// flow control: input ready is low while a frame is rotating out (len <= 64)
// reset: all pixel cells clear to black, comet idle, strip length 60
module led_comet_pattern_generator_unit #(
    parameter int MAX_PIXELS  = 64,
    parameter int TAIL_STEPS  = 10,
    parameter int FADE_AMOUNT = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input transaction
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  logic [7:0]                 red_in,
    input  logic [7:0]                 green_in,
    input  logic [7:0]                 blue_in,
    input  logic [15:0]                period_in,
    // result transaction
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [5:0]                 pixel_index,
    output logic [7:0]                 red_out,
    output logic [7:0]                 green_out,
    output logic [7:0]                 blue_out,
    output logic                       frame_end,
    // configuration write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lcpg_pkg::LEN_W-1:0] strip_length
);
    import lcpg_pkg::*;

    // head runs to strip length plus the tail
    localparam int         HEAD_W = $clog2((1 << LEN_W) + TAIL_STEPS);
    localparam logic [8:0] SCALE  = 9'(256 - (FADE_AMOUNT & 255));

    // configuration and comet state
    logic [LEN_W-1:0]  strip_len_reg, strip_len_next;
    logic              running_reg, running_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    pixel_t            colour_reg, colour_next;
    logic [15:0]       period_reg, period_next;

    // frame sequencer
    logic              busy_reg, busy_next;
    logic [LEN_W-1:0]  count_reg, count_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [5:0]        pixel_index_reg;
    pixel_t            pixel_out_reg;
    logic              frame_end_reg;

    logic              in_fire;
    logic              step_fire;
    logic              frame_last;
    logic              head_hit;
    logic [15:0]       elapsed_inc;
    logic [LEN_W-1:0]  len_eff;
    pixel_t            ring_head;
    pixel_t            feedback;
    cell_ctrl_t        cell_ctrl;
    pixel_t            cell_pixel [MAX_PIXELS];

    // length out of range: zero acts as one, above the ring size acts as the ring size
    always_comb
    begin
        if (strip_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (int'(strip_len_reg) > MAX_PIXELS)
        begin
            len_eff = LEN_W'(MAX_PIXELS);
        end
        else
        begin
            len_eff = strip_len_reg;
        end
    end

    assign in_ready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    // during a frame, one pixel leaves cell 0 whenever the output register is free or draining
    assign step_fire  = busy_reg && (!out_valid_reg || out_ready);
    assign frame_last = count_reg == (len_eff - LEN_W'(1));

    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;

    // the head pixel takes the comet colour in place of its faded value
    assign ring_head = cell_pixel[0];
    assign head_hit  = (head_reg < HEAD_W'(len_eff)) && (HEAD_W'(count_reg) == head_reg);
    assign feedback  = head_hit ? colour_reg : fade_pixel(ring_head, SCALE);

    assign cell_ctrl.shift = step_fire;
    assign cell_ctrl.len   = len_eff;

    // ring of cells: each shifts towards cell 0, the last active one takes the feedback
    for (genvar i = 0; i < MAX_PIXELS; i++)
    begin : g_cell
        if (i == MAX_PIXELS - 1)
        begin : g_top
            lcpg_cell #(
                .INDEX(i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .neighbour(feedback),
                .feedback (feedback),
                .pixel    (cell_pixel[i])
            );
        end
        else
        begin : g_mid
            lcpg_cell #(
                .INDEX(i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .neighbour(cell_pixel[i+1]),
                .feedback (feedback),
                .pixel    (cell_pixel[i])
            );
        end
    end

    // control: start, tick timing, frame sequencing
    always_comb
    begin
        strip_len_next = strip_len_reg;
        running_next   = running_reg;
        head_next      = head_reg;
        elapsed_next   = elapsed_reg;
        colour_next    = colour_reg;
        period_next    = period_reg;
        busy_next      = busy_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;

        if (cfg_valid && cfg_ready)
        begin
            strip_len_next = strip_length;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            if (operation == OP_START)
            begin
                // restart: arm the timer so the next tick steps at once
                colour_next.red   = red_in;
                colour_next.green = green_in;
                colour_next.blue  = blue_in;
                period_next       = period_in;
                elapsed_next      = period_in;
                head_next         = '0;
                running_next      = 1'b1;
            end
            else if (running_reg)
            begin
                if (elapsed_inc >= period_reg)
                begin
                    elapsed_next = '0;
                    busy_next    = 1'b1;
                    count_next   = '0;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
        end

        if (step_fire)
        begin
            out_valid_next = 1'b1;
            count_next     = count_reg + LEN_W'(1);
            if (frame_last)
            begin
                busy_next = 1'b0;
                // the step that finds the head at the tail end stops the comet
                if (head_reg < HEAD_W'(len_eff) + HEAD_W'(TAIL_STEPS))
                begin
                    head_next = head_reg + HEAD_W'(1);
                end
                else
                begin
                    running_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_len_reg <= LEN_W'(60);
            running_reg   <= 1'b0;
            head_reg      <= '0;
            elapsed_reg   <= '0;
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            strip_len_reg <= strip_len_next;
            running_reg   <= running_next;
            head_reg      <= head_next;
            elapsed_reg   <= elapsed_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        colour_reg <= colour_next;
        period_reg <= period_next;
        if (step_fire)
        begin
            pixel_index_reg <= 6'(count_reg);
            pixel_out_reg   <= feedback;
            frame_end_reg   <= frame_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign red_out     = pixel_out_reg.red;
    assign green_out   = pixel_out_reg.green;
    assign blue_out    = pixel_out_reg.blue;
    assign frame_end   = frame_end_reg;

    // the pixel counter never runs past the strip
    a_count_in_strip: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg < len_eff))
        else $error("pixel counter beyond strip length");

    // a frame only rotates while the comet is running
    a_busy_running: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> running_reg)
        else $error("frame emission with comet stopped");

    // the last pixel of a frame ends the sequence
    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step_fire && frame_last) |=> (!busy_reg && out_valid_reg && frame_end_reg))
        else $error("frame did not close on its last pixel");

    // a start does not begin a frame
    a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (operation == OP_START)) |=> !busy_reg)
        else $error("start transaction began a frame");

endmodule

>>> design/lcpg_cell.sv
// one pixel cell of the frame ring: holds a pixel, takes its neighbour's on a shift
// (the feedback instead if it is the last active cell); depends on lcpg_pkg
module lcpg_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lcpg_pkg::cell_ctrl_t ctrl,
    input  lcpg_pkg::pixel_t    neighbour,
    input  lcpg_pkg::pixel_t    feedback,
    output lcpg_pkg::pixel_t    pixel
);
    import lcpg_pkg::*;

    pixel_t pixel_reg;
    pixel_t pixel_next;
    logic   active;
    logic   last;

    // cells beyond the strip length hold their value
    assign active = int'(ctrl.len) > INDEX;
    assign last   = int'(ctrl.len) == (INDEX + 1);

    always_comb
    begin
        pixel_next = pixel_reg;
        if (ctrl.shift && active)
        begin
            if (last)
            begin
                pixel_next = feedback;
            end
            else
            begin
                pixel_next = neighbour;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_reg <= '0;
        end
        else
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixel = pixel_reg;

endmodule
